### rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned TickW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Press status codes; the event field uses the same codes, idle meaning none.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE    = 2'd0,
    CFG_LONG_HOLD   = 2'd1,
    CFG_STATUS_HOLD = 2'd2
  } cfg_idx_e;

  localparam logic [CfgW-1:0] DebounceRst    = 16'd50;
  localparam logic [CfgW-1:0] LongHoldRst    = 16'd2000;
  localparam logic [CfgW-1:0] StatusHoldRst  = 16'd3000;

  // One poll.
  typedef struct packed {
    logic [TickW-1:0] now_tick;
    logic             pressed_level;
  } poll_t;

  // One classification result.
  typedef struct packed {
    status_e press_status;
    status_e status_event;
  } result_t;

endpackage

### rtl/core/bpc_if.sv
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels for polls and results.
// ----------------------------------------------------------------------------
interface bpc_poll_if;
  import bpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [TickW-1:0] now_tick;
  logic             pressed_level;

  modport source (output valid, output now_tick, output pressed_level, input ready);
  modport sink   (input valid, input now_tick, input pressed_level, output ready);
endinterface

interface bpc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_status;
  logic [1:0] status_event;

  modport source (output valid, output press_status, output status_event, input ready);
  modport sink   (input valid, input press_status, input status_event, output ready);
endinterface

### rtl/core/bpc_in_stage.sv
// ----------------------------------------------------------------------------
// bpc_in_stage
// Input register: holds one poll until the classifier consumes it.
// ----------------------------------------------------------------------------
module bpc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bpc_pkg::poll_t in_poll_i,
  output logic           poll_valid_o,
  input  logic           poll_take_i,
  output bpc_pkg::poll_t poll_o
);
  import bpc_pkg::*;

  logic  valid_q, valid_d;
  poll_t poll_q;

  // Take a new word whenever the register is empty or being drained.
  assign in_ready_o = !valid_q || poll_take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !poll_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on accept.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      poll_q <= in_poll_i;
    end
  end

  assign poll_valid_o = valid_q;
  assign poll_o       = poll_q;

endmodule

### rtl/core/bpc_engine.sv
// ----------------------------------------------------------------------------
// bpc_engine
// Press tracking state, configuration registers and the per-poll update.
// ----------------------------------------------------------------------------
module bpc_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bpc_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                           step_i,
  input  bpc_pkg::poll_t                 poll_i,
  output bpc_pkg::result_t               result_o
);
  import bpc_pkg::*;

  logic [CfgW-1:0]  debounce_q, long_hold_q, status_hold_q;
  logic             held_q, held_d;
  logic [TickW-1:0] start_q, start_d;
  logic             short_q, short_d;
  logic             long_q, long_d;
  status_e          cur_q, cur_d, cur_mid;
  status_e          rep_q;
  logic [TickW-1:0] stamp_q, stamp_d;
  logic [TickW-1:0] dur;
  logic [TickW-1:0] new_stamp;
  status_e          event_s;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DebounceRst;
      long_hold_q   <= LongHoldRst;
      status_hold_q <= StatusHoldRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:    debounce_q    <= cfg_data_i;
        CFG_LONG_HOLD:   long_hold_q   <= cfg_data_i;
        CFG_STATUS_HOLD: status_hold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Event for a status change seen at poll start; a change to idle is silent.
  assign event_s = (cur_q != rep_q) ? cur_q : ST_IDLE;

  // Press start and length; on release the start is unchanged, so one subtract
  // serves both the hold time and the released press length.
  assign start_d   = (poll_i.pressed_level && !held_q) ? poll_i.now_tick : start_q;
  assign held_d    = poll_i.pressed_level;
  assign dur       = poll_i.now_tick - start_d;
  assign new_stamp = poll_i.now_tick + {{(TickW-CfgW){1'b0}}, status_hold_q};

  // Classification of this poll.
  always_comb begin
    short_d = short_q;
    long_d  = long_q;
    cur_mid = cur_q;
    stamp_d = stamp_q;
    if (held_d) begin
      short_d = 1'b1;
      if (dur >= {{(TickW-CfgW){1'b0}}, long_hold_q}) begin
        short_d = 1'b0;
        if (long_q) begin
          long_d  = 1'b0;
          cur_mid = ST_LONG;
          stamp_d = new_stamp;
        end
      end
    end else begin
      long_d = 1'b1;
      if (short_q) begin
        short_d = 1'b0;
        if (dur > {{(TickW-CfgW){1'b0}}, debounce_q}) begin
          cur_mid = ST_SHORT;
          stamp_d = new_stamp;
        end
      end
    end
    cur_d = cur_mid;
    if (cur_mid != ST_IDLE && poll_i.now_tick > stamp_d) begin
      cur_d = ST_IDLE;
    end
  end

  // State update, one poll per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      start_q <= '0;
      short_q <= 1'b0;
      long_q  <= 1'b0;
      cur_q   <= ST_IDLE;
      rep_q   <= ST_IDLE;
      stamp_q <= '0;
    end else if (step_i) begin
      held_q  <= held_d;
      start_q <= start_d;
      short_q <= short_d;
      long_q  <= long_d;
      cur_q   <= cur_d;
      rep_q   <= cur_q;
      stamp_q <= stamp_d;
    end
  end

  assign result_o.press_status = cur_d;
  assign result_o.status_event = event_s;

endmodule

### rtl/core/bpc_out_stage.sv
// ----------------------------------------------------------------------------
// bpc_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module bpc_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bpc_pkg::result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bpc_pkg::result_t result_o
);
  import bpc_pkg::*;

  logic    valid_q;
  result_t result_q;

  // The register can take a word when empty or when its word leaves now.
  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### rtl/core/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// A poll is held in the input register, then its result in the result register.
// Throughput: one poll per cycle while results are taken; state updates in the
// single combinational pass between the input and result registers.
// Reset clears all press state, the status to idle and the configuration to
// its defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_press_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bpc_pkg::CfgW-1:0]    cfg_data_i,
  bpc_poll_if.sink                    in_i,
  bpc_result_if.source                out_o
);
  import bpc_pkg::*;

  poll_t   in_poll;
  poll_t   poll;
  logic    poll_valid;
  logic    out_free;
  logic    step;
  result_t result_d;
  result_t result_q;

  assign in_poll.now_tick      = in_i.now_tick;
  assign in_poll.pressed_level = in_i.pressed_level;

  // A poll moves through the engine when the result register can take it.
  assign step = poll_valid && out_free;

  bpc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_poll_i    (in_poll),
    .poll_valid_o (poll_valid),
    .poll_take_i  (step),
    .poll_o       (poll)
  );

  bpc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .poll_i     (poll),
    .result_o   (result_d)
  );

  bpc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (result_d),
    .free_o      (out_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (result_q)
  );

  assign out_o.press_status = result_q.press_status;
  assign out_o.status_event = result_q.status_event;

endmodule

### sim/button_press_classifier_checker.sv
// ----------------------------------------------------------------------------
// button_press_classifier_checker
// Watches the poll and result channels and the register write port of the
// button press classifier. It predicts the status and event word of each
// accepted poll and compares every accepted result word, in order, against it.
// ----------------------------------------------------------------------------
module button_press_classifier_checker
  import bpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  bpc_poll_if                poll_i,
  bpc_result_if              res_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  // Register copies.
  logic [CfgW-1:0]  debounce_cfg;
  logic [CfgW-1:0]  long_hold_cfg;
  logic [CfgW-1:0]  status_hold_cfg;

  // Predicted press state.
  logic             held;
  logic [TickW-1:0] press_start;
  logic [TickW-1:0] last_len;
  logic             short_armed;
  logic             long_armed;
  status_e          cur_status;
  status_e          rep_status;
  logic [TickW-1:0] timeout_at;

  // Predicted result words, oldest first.
  result_t          status_queue[$];

  // Classify one poll and advance the predicted press state.
  task automatic classify_poll(input poll_t p, output result_t r);
    logic [TickW-1:0] held_len;
    status_e          ev;
    ev = ST_IDLE;
    // A change to idle is tracked but never reported as an event.
    if (cur_status != rep_status) begin
      rep_status = cur_status;
      if (cur_status == ST_SHORT || cur_status == ST_LONG) begin
        ev = cur_status;
      end
    end
    if (p.pressed_level) begin
      if (!held) begin
        press_start = p.now_tick;
      end
      held = 1'b1;
    end else begin
      last_len = p.now_tick - press_start;
      held     = 1'b0;
    end
    if (held) begin
      short_armed = 1'b1;
      held_len    = p.now_tick - press_start;
      if (held_len >= {16'd0, long_hold_cfg}) begin
        short_armed = 1'b0;
        // Long hold is only given once a release has armed it.
        if (long_armed) begin
          long_armed = 1'b0;
          cur_status = ST_LONG;
          timeout_at = p.now_tick + {16'd0, status_hold_cfg};
        end
      end
    end else begin
      long_armed = 1'b1;
      if (short_armed) begin
        short_armed = 1'b0;
        if (last_len > {16'd0, debounce_cfg}) begin
          cur_status = ST_SHORT;
          timeout_at = p.now_tick + {16'd0, status_hold_cfg};
        end
      end
    end
    // Plain unsigned compare, so a wrapped stamp can expire at once.
    if (cur_status != ST_IDLE && p.now_tick > timeout_at) begin
      cur_status = ST_IDLE;
    end
    r.press_status = cur_status;
    r.status_event = ev;
  endtask

  // Compare result words, then predict new polls and track register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_res;
    poll_t   p;
    result_t r;
    if (!rst_ni) begin
      debounce_cfg    = DebounceRst;
      long_hold_cfg   = LongHoldRst;
      status_hold_cfg = StatusHoldRst;
      held            = 1'b0;
      press_start     = '0;
      last_len        = '0;
      short_armed     = 1'b0;
      long_armed      = 1'b0;
      cur_status      = ST_IDLE;
      rep_status      = ST_IDLE;
      timeout_at      = '0;
      status_queue.delete();
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (status_queue.size() == 0) begin
          if (fail_count_o < MaxReports) begin
            $display("%0t: result word with none expected: status %0d event %0d",
                     $realtime, res_i.press_status, res_i.status_event);
          end
          fail_count_o++;
        end else begin
          exp_res = status_queue.pop_front();
          if (res_i.press_status !== exp_res.press_status ||
              res_i.status_event !== exp_res.status_event) begin
            if (fail_count_o < MaxReports) begin
              $display("%0t: mismatch: status exp %0d got %0d, event exp %0d got %0d",
                       $realtime, exp_res.press_status, res_i.press_status,
                       exp_res.status_event, res_i.status_event);
            end
            fail_count_o++;
          end
        end
      end
      if (poll_i.valid && poll_i.ready) begin
        p.now_tick      = poll_i.now_tick;
        p.pressed_level = poll_i.pressed_level;
        classify_poll(p, r);
        status_queue.push_back(r);
      end
      // Writes to an index past the last register are dropped.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE:    debounce_cfg    = cfg_data_i;
          CFG_LONG_HOLD:   long_hold_cfg   = cfg_data_i;
          CFG_STATUS_HOLD: status_hold_cfg = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = status_queue.size();
    end
  end

endmodule

### sim/button_press_classifier_tb.sv
// ----------------------------------------------------------------------------
// button_press_classifier_tb
// Drives polls into the button press classifier in bursts, stalls the result
// channel on a random pattern and rewrites the configuration registers between phases.
// A directed press sequence comes first, then random press and release runs
// with some noise under several register settings, extremes included.
// ----------------------------------------------------------------------------
module button_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned PollsPerPhase = 150;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned NoisePct     = 10;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        cycle_count;
  int unsigned        burst_left;

  bpc_poll_if   poll_if ();
  bpc_result_if res_if ();

  button_press_classifier u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (poll_if.sink),
    .out_o      (res_if.source)
  );

  button_press_classifier_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .poll_i       (poll_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result stalls: at each wrap of the stall phase counter pick free flow, a fixed pattern or random draws.
  initial begin
    logic [15:0] stall_pattern;
    logic [3:0]  stall_phase;
    int unsigned stall_mode;
    res_if.ready  = 1'b0;
    stall_phase   = '0;
    stall_pattern = '0;
    stall_mode    = 0;
    forever begin
      @(negedge clk);
      if (stall_phase == 0) begin
        stall_mode    = $urandom_range(0, 3);
        stall_pattern = 16'($urandom);
      end
      case (stall_mode)
        0:       res_if.ready <= 1'b1;
        3:       res_if.ready <= ($urandom_range(0, 3) != 0);
        default: res_if.ready <= stall_pattern[stall_phase];
      endcase
      stall_phase++;
    end
  end

  // One register write, held for a single cycle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Offer one poll word; a new burst starts after a random gap.
  task automatic send_poll(input logic [TickW-1:0] tick, input logic lvl);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        poll_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    poll_if.valid         <= 1'b1;
    poll_if.now_tick      <= tick;
    poll_if.pressed_level <= lvl;
    do @(posedge clk); while (!poll_if.ready);
  endtask

  // Stop sending and wait until every result word is back.
  task automatic drain;
    @(negedge clk);
    poll_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // One random phase: set the registers, then press and release runs.
  task automatic run_phase(input int unsigned phase_no);
    logic [CfgW-1:0]  debounce;
    logic [CfgW-1:0]  long_hold;
    logic [CfgW-1:0]  status_hold;
    logic [TickW-1:0] tick;
    logic             lvl;
    logic             poll_lvl;
    int unsigned      step_max;
    int unsigned      run_left;
    int unsigned      roll;
    if (phase_no == 0) begin
      debounce    = '0;
      long_hold   = 16'd1;
      status_hold = '0;
      step_max    = 12;
    end else if (phase_no == 1) begin
      debounce    = 16'hFFFF;
      long_hold   = 16'hFFFF;
      status_hold = 16'hFFFF;
      step_max    = 20000;
    end else if (phase_no % 3 == 0) begin
      debounce    = CfgW'($urandom_range(0, 65535));
      long_hold   = CfgW'($urandom_range(1, 65535));
      status_hold = CfgW'($urandom_range(0, 65535));
      step_max    = 20000;
    end else begin
      debounce    = CfgW'($urandom_range(0, 30));
      long_hold   = CfgW'($urandom_range(1, 80));
      status_hold = CfgW'($urandom_range(0, 100));
      step_max    = 12;
    end
    drain();
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_LONG_HOLD, long_hold);
    write_reg(CFG_STATUS_HOLD, status_hold);
    // The spare index must not disturb any register.
    write_reg(CfgIdxUnused, CfgW'($urandom_range(0, 65535)));

    // Start some phases just below the tick wrap.
    if ($urandom_range(0, 2) == 0) begin
      tick = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    end else begin
      tick = $urandom;
    end
    lvl      = 1'b0;
    run_left = 0;
    for (int unsigned i = 0; i < PollsPerPhase; i++) begin
      if (run_left == 0) begin
        lvl      = ~lvl;
        run_left = $urandom_range(1, 12);
      end
      run_left--;
      poll_lvl = lvl;
      roll     = $urandom_range(0, 99);
      if (roll < NoisePct) begin
        // Noise: a tick jump, a level glitch or a tick going backwards.
        case ($urandom_range(0, 2))
          0:       tick = $urandom;
          1:       poll_lvl = 1'($urandom_range(0, 1));
          default: tick = tick - $urandom_range(0, step_max);
        endcase
      end else begin
        tick = tick + $urandom_range(0, step_max);
      end
      send_poll(tick, poll_lvl);
    end
  endtask

  // Main sequence.
  initial begin
    cfg_we                = 1'b0;
    cfg_idx               = CFG_DEBOUNCE;
    cfg_data              = '0;
    poll_if.valid         = 1'b0;
    poll_if.now_tick      = '0;
    poll_if.pressed_level = 1'b0;
    burst_left            = 0;
    rst_n                 = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // First hold after reset reaches the long hold time but gives nothing.
    send_poll(32'd100, 1'b1);
    send_poll(32'd3000, 1'b1);
    send_poll(32'd3001, 1'b0);
    // Short press, then its event on the next poll.
    send_poll(32'd4000, 1'b1);
    send_poll(32'd4100, 1'b0);
    send_poll(32'd4101, 1'b0);
    // A press exactly as long as the debounce time does not count.
    send_poll(32'd8000, 1'b1);
    send_poll(32'd8050, 1'b0);
    // One tick longer does.
    send_poll(32'd8100, 1'b1);
    send_poll(32'd8151, 1'b0);
    // Status stays at its stamp, goes idle one tick later, no event for idle.
    send_poll(32'd11151, 1'b0);
    send_poll(32'd11152, 1'b0);
    send_poll(32'd11153, 1'b0);
    // Long hold, now armed by the earlier releases.
    send_poll(32'd12000, 1'b1);
    send_poll(32'd13999, 1'b1);
    send_poll(32'd14000, 1'b1);
    send_poll(32'd14001, 1'b1);
    send_poll(32'd14100, 1'b0);
    // Press across the tick wrap; its stamp then expires at the top tick.
    send_poll(32'hFFFF_FFF0, 1'b1);
    send_poll(32'h0000_0050, 1'b0);
    send_poll(32'h0000_0051, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0);
    // Zero length press.
    send_poll(32'h0000_0000, 1'b1);
    send_poll(32'h0000_0000, 1'b0);

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      run_phase(ph);
    end

    @(negedge clk);
    poll_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
